// ===== rtl/plm_pkg.sv =====
// Shared types and codes for the positional list engine.
`timescale 1ns / 1ps
`default_nettype none

package plm_pkg;

	localparam int ValueW  = 32;
	localparam int ActionW = 3;
	localparam int PosW    = 5;
	localparam int StatusW = 2;
	localparam int CountW  = 5;

	typedef enum logic [ActionW-1:0] {
		ACT_PUSH_FRONT = 3'd0,
		ACT_PUSH_BACK  = 3'd1,
		ACT_INSERT_AT  = 3'd2,
		ACT_POP_FRONT  = 3'd3,
		ACT_POP_BACK   = 3'd4,
		ACT_REMOVE_AT  = 3'd5,
		ACT_SEARCH     = 3'd6
	} plm_action_t;

	typedef enum logic [StatusW-1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_RANGE = 2'd2,
		ST_FULL  = 2'd3
	} plm_status_t;

	typedef enum logic [1:0] {
		OP_HOLD      = 2'd0,
		OP_LOAD      = 2'd1,
		OP_FROM_PREV = 2'd2,
		OP_FROM_NEXT = 2'd3
	} plm_op_t;

	typedef struct packed {
		plm_op_t op;
		logic    cmp_en;
		logic    cap;
	} plm_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/plm_cell.sv =====
// One list slot: holds an entry, shifts with its neighbors and compares against the key.
`timescale 1ns / 1ps
`default_nettype none

module plm_cell (
	input  wire logic                         clk,
	input  wire plm_pkg::plm_ctl_t            ctl,
	input  wire logic [plm_pkg::ValueW-1:0]   value,
	input  wire logic [plm_pkg::ValueW-1:0]   prev_data,
	input  wire logic [plm_pkg::ValueW-1:0]   next_data,
	output logic      [plm_pkg::ValueW-1:0]   data,
	output logic                              match
);

	logic [plm_pkg::ValueW-1:0] data_q;
	logic                       match_q;

	always_ff @(posedge clk) begin
		case (ctl.op)
			plm_pkg::OP_LOAD:      data_q <= value;
			plm_pkg::OP_FROM_PREV: data_q <= prev_data;
			plm_pkg::OP_FROM_NEXT: data_q <= next_data;
			default:               data_q <= data_q;
		endcase
	end

	// compare against the entry as it stood before this transaction
	always_ff @(posedge clk) begin
		if (ctl.cap) begin
			match_q <= ctl.cmp_en && (data_q == value);
		end
	end

	assign data  = data_q;
	assign match = match_q;

endmodule

`default_nettype wire

// ===== rtl/positional_list_engine.sv =====
// Positional list engine: bounded ordered list of signed 32-bit values held in a row of cells.
//
// Input channel (in_valid/in_ready) carries action, value and position; every accepted
// transaction yields exactly one result on the output channel (out_valid/out_ready) with
// status, found and count. Insert, remove and search act on all cells at once: each cell
// loads, takes its left or right neighbor's entry, or holds, in the cycle of acceptance,
// and each cell registers its own key compare at the same time.
// The result passes two registers in order: the cell compare, then the OR of the compare
// flags into the output register. Throughput: one transaction per cycle while the receiver
// keeps up, as the cell row takes each action in a single broadcast.
// The output register and the compare stage form a two-deep path, so a new transaction is
// taken while a finished result waits; when the receiver stalls with both stages full,
// in_ready drops until out_ready returns.
// Reset empties the list (length zero) and clears both stages; stored entries are not
// cleared, since slots at or past the length are never read.
// count reports the length after the action, truncated to 5 bits.
`timescale 1ns / 1ps
`default_nettype none

module positional_list_engine #(
	parameter int DEPTH = 16
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic [plm_pkg::ActionW-1:0]   action,
	input  wire logic signed [plm_pkg::ValueW-1:0] value,
	input  wire logic [plm_pkg::PosW-1:0]      position,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic [plm_pkg::StatusW-1:0]        status,
	output logic                               found,
	output logic [plm_pkg::CountW-1:0]         count
);

	localparam int LW = $clog2(DEPTH + 1);
	localparam int CW = ((LW > plm_pkg::PosW) ? LW : plm_pkg::PosW) + 1;

	logic [LW-1:0] len_q;
	logic [LW-1:0] len_d;

	logic                            s1_valid_q;
	plm_pkg::plm_status_t            status_s1;
	logic [plm_pkg::CountW-1:0]      count_s1;

	logic                            out_valid_q;
	logic [plm_pkg::StatusW-1:0]     status_q;
	logic                            found_q;
	logic [plm_pkg::CountW-1:0]      count_q;

	logic accept;
	logic advance;

	plm_pkg::plm_action_t act;
	plm_pkg::plm_status_t status_d;
	logic [CW-1:0] pos_w;
	logic [CW-1:0] len_w;
	logic [CW-1:0] idx_w;
	logic          do_ins;
	logic          do_rem;
	logic          do_srch;
	logic          is_full;
	logic          is_empty;

	plm_pkg::plm_ctl_t          ctl   [DEPTH];
	logic [plm_pkg::ValueW-1:0] cdata [DEPTH];
	logic [DEPTH-1:0]           match;
	logic                       any_match;

	assign advance  = s1_valid_q && (!out_valid_q || out_ready);
	assign in_ready = !s1_valid_q || advance;
	assign accept   = in_valid && in_ready;

	assign is_full  = (len_q == LW'(DEPTH));
	assign is_empty = (len_q == '0);

	// decode the action against the current length
	always_comb begin
		act      = plm_pkg::plm_action_t'(action);
		pos_w    = CW'(position);
		len_w    = CW'(len_q);
		status_d = plm_pkg::ST_OK;
		idx_w    = '0;
		do_ins   = 1'b0;
		do_rem   = 1'b0;
		do_srch  = 1'b0;
		case (act)
			plm_pkg::ACT_PUSH_FRONT, plm_pkg::ACT_PUSH_BACK, plm_pkg::ACT_INSERT_AT: begin
				if (is_full) begin
					status_d = plm_pkg::ST_FULL;
				end else if (act == plm_pkg::ACT_PUSH_FRONT) begin
					do_ins = 1'b1;
				end else if (act == plm_pkg::ACT_PUSH_BACK) begin
					do_ins = 1'b1;
					idx_w  = len_w;
				end else if (pos_w == '0 || pos_w > len_w + CW'(1)) begin
					status_d = plm_pkg::ST_RANGE;
				end else begin
					do_ins = 1'b1;
					idx_w  = pos_w - CW'(1);
				end
			end
			plm_pkg::ACT_POP_FRONT, plm_pkg::ACT_POP_BACK, plm_pkg::ACT_REMOVE_AT: begin
				if (is_empty) begin
					status_d = plm_pkg::ST_EMPTY;
				end else if (act == plm_pkg::ACT_POP_FRONT) begin
					do_rem = 1'b1;
				end else if (act == plm_pkg::ACT_POP_BACK) begin
					do_rem = 1'b1;
					idx_w  = len_w - CW'(1);
				end else if (pos_w == '0 || pos_w > len_w) begin
					status_d = plm_pkg::ST_RANGE;
				end else begin
					do_rem = 1'b1;
					idx_w  = pos_w - CW'(1);
				end
			end
			plm_pkg::ACT_SEARCH: begin
				if (is_empty) begin
					status_d = plm_pkg::ST_EMPTY;
				end else begin
					do_srch = 1'b1;
				end
			end
			default: begin
			end
		endcase

		if (do_ins) begin
			len_d = len_q + LW'(1);
		end else if (do_rem) begin
			len_d = len_q - LW'(1);
		end else begin
			len_d = len_q;
		end
	end

	// broadcast a per-cell op: cells past the slot shift back on insert, forward on removal
	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			ctl[i].op     = plm_pkg::OP_HOLD;
			ctl[i].cmp_en = do_srch && (CW'(i) < len_w);
			ctl[i].cap    = accept;
			if (accept && do_ins) begin
				if (CW'(i) == idx_w) begin
					ctl[i].op = plm_pkg::OP_LOAD;
				end else if (CW'(i) > idx_w) begin
					ctl[i].op = plm_pkg::OP_FROM_PREV;
				end
			end else if (accept && do_rem && CW'(i) >= idx_w) begin
				ctl[i].op = plm_pkg::OP_FROM_NEXT;
			end
		end
	end

	for (genvar g = 0; g < DEPTH; g++) begin : g_cell
		logic [plm_pkg::ValueW-1:0] prev_d;
		logic [plm_pkg::ValueW-1:0] next_d;

		if (g == 0) begin : g_first
			assign prev_d = value;
		end else begin : g_mid_p
			assign prev_d = cdata[g-1];
		end

		if (g == DEPTH - 1) begin : g_last
			assign next_d = cdata[g];
		end else begin : g_mid_n
			assign next_d = cdata[g+1];
		end

		plm_cell u_cell (
			.clk       (clk),
			.ctl       (ctl[g]),
			.value     (value),
			.prev_data (prev_d),
			.next_data (next_d),
			.data      (cdata[g]),
			.match     (match[g])
		);
	end

	assign any_match = |match;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q       <= '0;
			s1_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				len_q <= len_d;
			end
			if (accept) begin
				s1_valid_q <= 1'b1;
			end else if (advance) begin
				s1_valid_q <= 1'b0;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_s1 <= status_d;
			count_s1  <= plm_pkg::CountW'(len_d);
		end
		if (advance) begin
			status_q <= status_s1;
			found_q  <= any_match;
			count_q  <= count_s1;
		end
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign found     = found_q;
	assign count     = count_q;

endmodule

`default_nettype wire

// ===== dv/positional_list_engine_tb.sv =====
// Testbench for the positional list engine: queued stimulus, list predictor, result checker.
`timescale 1ns / 1ps

module positional_list_engine_tb;

	localparam int ListDepth     = 16;
	localparam int NumRandom     = 1872;
	localparam int WatchdogLimit = 2000;
	localparam int TailCycles    = 10;
	localparam int MaxReports    = 10;
	localparam logic [plm_pkg::ActionW-1:0] ActIgnored = 3'd7;

	// idle percentages per phase
	localparam int SendIdlePct [3] = '{30, 65, 0};
	localparam int RecvIdlePct [3] = '{65, 30, 0};

	typedef struct {
		logic [plm_pkg::ActionW-1:0]       act;
		logic signed [plm_pkg::ValueW-1:0] val;
		logic [plm_pkg::PosW-1:0]          pos;
		logic                              hold_for_drain;
		int                                phase;
	} list_cmd_t;

	typedef struct packed {
		plm_pkg::plm_status_t        status;
		logic                        found;
		logic [plm_pkg::CountW-1:0]  count;
	} list_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [plm_pkg::ActionW-1:0] action = '0;
	logic signed [plm_pkg::ValueW-1:0] value = '0;
	logic [plm_pkg::PosW-1:0] position = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [plm_pkg::StatusW-1:0] status;
	logic found;
	logic [plm_pkg::CountW-1:0] count;

	list_cmd_t    queued_cmds [$];
	list_result_t due_results [$];
	int total_cmds = 0;
	int accepted_cmds = 0;
	int fail_count = 0;
	int stall_cycles = 0;
	int cur_phase = 0;
	logic item_taken = 1'b0;

	// predictor state
	logic signed [plm_pkg::ValueW-1:0] list_vals [ListDepth];
	int unsigned list_len = 0;

	positional_list_engine #(.DEPTH(ListDepth)) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.action    (action),
		.value     (value),
		.position  (position),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.found     (found),
		.count     (count)
	);

	always #1 clk = ~clk;

	function automatic void insert_entry(int unsigned idx,
			logic signed [plm_pkg::ValueW-1:0] v);
		for (int unsigned i = list_len; i > idx; i--) begin
			list_vals[i] = list_vals[i - 1];
		end
		list_vals[idx] = v;
		list_len++;
	endfunction

	function automatic void remove_entry(int unsigned idx);
		for (int unsigned i = idx; i + 1 < list_len; i++) begin
			list_vals[i] = list_vals[i + 1];
		end
		list_len--;
	endfunction

	function automatic list_result_t apply_list_action(logic [plm_pkg::ActionW-1:0] act,
			logic signed [plm_pkg::ValueW-1:0] val, logic [plm_pkg::PosW-1:0] pos);
		list_result_t r;
		r.status = plm_pkg::ST_OK;
		r.found  = 1'b0;
		case (act)
			plm_pkg::ACT_PUSH_FRONT, plm_pkg::ACT_PUSH_BACK, plm_pkg::ACT_INSERT_AT: begin
				// full check wins over the position check
				if (list_len >= ListDepth)
					r.status = plm_pkg::ST_FULL;
				else if (act == plm_pkg::ACT_PUSH_FRONT)
					insert_entry(0, val);
				else if (act == plm_pkg::ACT_PUSH_BACK)
					insert_entry(list_len, val);
				else if (pos == 0 || pos > list_len + 1)
					r.status = plm_pkg::ST_RANGE;
				else
					insert_entry(pos - 1, val);
			end
			plm_pkg::ACT_POP_FRONT, plm_pkg::ACT_POP_BACK, plm_pkg::ACT_REMOVE_AT: begin
				if (list_len == 0)
					r.status = plm_pkg::ST_EMPTY;
				else if (act == plm_pkg::ACT_POP_FRONT)
					remove_entry(0);
				else if (act == plm_pkg::ACT_POP_BACK)
					remove_entry(list_len - 1);
				else if (pos == 0 || pos > list_len)
					r.status = plm_pkg::ST_RANGE;
				else
					remove_entry(pos - 1);
			end
			plm_pkg::ACT_SEARCH: begin
				if (list_len == 0)
					r.status = plm_pkg::ST_EMPTY;
				else
					for (int unsigned i = 0; i < list_len; i++)
						if (list_vals[i] == val) r.found = 1'b1;
			end
			default: ;
		endcase
		r.count = list_len[plm_pkg::CountW-1:0];
		return r;
	endfunction

	task automatic queue_cmd(logic [plm_pkg::ActionW-1:0] act,
			logic signed [plm_pkg::ValueW-1:0] val,
			logic [plm_pkg::PosW-1:0] pos, logic hold_for_drain, int phase);
		list_cmd_t c;
		c.act = act;
		c.val = val;
		c.pos = pos;
		c.hold_for_drain = hold_for_drain;
		c.phase = phase;
		queued_cmds.push_back(c);
	endtask

	// driver: present transactions and randomize receiver stalls
	always @(negedge clk) begin
		if (arst_n) begin
			out_ready <= ($urandom_range(0, 99) >= RecvIdlePct[cur_phase]);
			if (!in_valid || item_taken) begin
				if (queued_cmds.size() != 0
						&& (!queued_cmds[0].hold_for_drain || due_results.size() == 0)
						&& $urandom_range(0, 99) >= SendIdlePct[queued_cmds[0].phase]) begin
					in_valid  <= 1'b1;
					action    <= queued_cmds[0].act;
					value     <= queued_cmds[0].val;
					position  <= queued_cmds[0].pos;
					cur_phase <= queued_cmds[0].phase;
					void'(queued_cmds.pop_front());
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor: check results, then predict newly accepted transactions
	always @(posedge clk) begin
		list_result_t want;
		item_taken <= in_valid && in_ready;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (due_results.size() == 0) begin
					if (fail_count < MaxReports)
						$display("unexpected result: status %0d found %0b count %0d",
							status, found, count);
					fail_count++;
				end else begin
					want = due_results.pop_front();
					if (status !== want.status || found !== want.found
							|| count !== want.count) begin
						if (fail_count < MaxReports)
							$display({"mismatch: status exp %0d got %0d, ",
								"found exp %0b got %0b, count exp %0d got %0d"},
								want.status, status, want.found, found,
								want.count, count);
						fail_count++;
					end
				end
			end
			if (in_valid && in_ready) begin
				due_results.push_back(apply_list_action(action, value, position));
				accepted_cmds++;
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles == WatchdogLimit) begin
			$display("status: fail");
			$finish;
		end
	end

	initial begin
		logic signed [plm_pkg::ValueW-1:0] pool [8];
		logic signed [plm_pkg::ValueW-1:0] val;
		logic [plm_pkg::ActionW-1:0] act;
		logic [plm_pkg::PosW-1:0] pos;
		int mode;
		int roll;

		// directed: empty-list cases
		queue_cmd(plm_pkg::ACT_SEARCH,    32'sd5, 5'd0, 1'b0, 0);
		queue_cmd(plm_pkg::ACT_POP_FRONT, 32'sd0, 5'd0, 1'b0, 0);
		queue_cmd(plm_pkg::ACT_POP_BACK,  32'sd0, 5'd0, 1'b0, 0);
		queue_cmd(plm_pkg::ACT_REMOVE_AT, 32'sd0, 5'd1, 1'b0, 0);
		queue_cmd(plm_pkg::ACT_INSERT_AT, 32'sd7, 5'd0, 1'b0, 0);
		queue_cmd(plm_pkg::ACT_INSERT_AT, 32'sd7, 5'd2, 1'b0, 0);
		// fill to capacity with all three insert flavors
		for (int k = 0; k < ListDepth; k++) begin
			case (k)
				0: val = 32'sh8000_0000;
				1: val = 32'sh7fff_ffff;
				2: val = -32'sd1;
				3: val = 32'sd0;
				default: val = $urandom;
			endcase
			case (k % 3)
				0: queue_cmd(plm_pkg::ACT_INSERT_AT, val, 5'(k / 2 + 1), 1'b0, 0);
				1: queue_cmd(plm_pkg::ACT_PUSH_FRONT, val, 5'd0, 1'b0, 0);
				default: queue_cmd(plm_pkg::ACT_PUSH_BACK, val, 5'd31, 1'b0, 0);
			endcase
		end
		queue_cmd(plm_pkg::ACT_PUSH_BACK, 32'sd9, 5'd0, 1'b0, 0);
		queue_cmd(plm_pkg::ACT_INSERT_AT, 32'sd9, 5'd0, 1'b0, 0);
		queue_cmd(plm_pkg::ACT_SEARCH, 32'sh7fff_ffff, 5'd0, 1'b0, 0);
		queue_cmd(plm_pkg::ACT_REMOVE_AT, 32'sd0, 5'd0, 1'b0, 0);
		queue_cmd(plm_pkg::ACT_REMOVE_AT, 32'sd0, 5'd17, 1'b0, 0);
		queue_cmd(plm_pkg::ACT_POP_FRONT, 32'sd0, 5'd0, 1'b0, 0);
		queue_cmd(plm_pkg::ACT_POP_BACK, 32'sd0, 5'd0, 1'b0, 0);

		// random: alternate growing, shrinking and mixed stretches
		pool = '{32'sh8000_0000, 32'sh7fff_ffff, 32'sd0, -32'sd1, 32'sd1, 32'sd2, 32'sd3,
			32'sd4};
		mode = 0;
		for (int i = 0; i < NumRandom; i++) begin
			if (i % 40 == 0)
				mode = $urandom_range(0, 2);
			roll = $urandom_range(0, 99);
			case (mode)
				0: begin
					if (roll < 75)
						act = plm_pkg::ActionW'($urandom_range(plm_pkg::ACT_PUSH_FRONT,
							plm_pkg::ACT_INSERT_AT));
					else if (roll < 88)
						act = plm_pkg::ACT_SEARCH;
					else if (roll < 97)
						act = plm_pkg::ActionW'($urandom_range(plm_pkg::ACT_POP_FRONT,
							plm_pkg::ACT_REMOVE_AT));
					else
						act = ActIgnored;
				end
				1: begin
					if (roll < 75)
						act = plm_pkg::ActionW'($urandom_range(plm_pkg::ACT_POP_FRONT,
							plm_pkg::ACT_REMOVE_AT));
					else if (roll < 88)
						act = plm_pkg::ACT_SEARCH;
					else if (roll < 97)
						act = plm_pkg::ActionW'($urandom_range(plm_pkg::ACT_PUSH_FRONT,
							plm_pkg::ACT_INSERT_AT));
					else
						act = ActIgnored;
				end
				default: act = plm_pkg::ActionW'($urandom_range(plm_pkg::ACT_PUSH_FRONT,
					ActIgnored));
			endcase
			roll = $urandom_range(0, 99);
			if (roll < 6)       pos = 5'd0;
			else if (roll < 12) pos = plm_pkg::PosW'($urandom_range(18, 31));
			else                pos = plm_pkg::PosW'($urandom_range(1, 17));
			// reuse recent values so searches hit
			if ($urandom_range(0, 1)) begin
				val = pool[3'($urandom_range(0, 7))];
			end else begin
				val = $urandom;
				pool[3'($urandom_range(0, 7))] = val;
			end
			queue_cmd(act, val, pos, (i == NumRandom / 3 || i == 2 * NumRandom / 3),
				i * 3 / NumRandom);
		end
		total_cmds = queued_cmds.size();

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		do @(negedge clk);
		while (accepted_cmds != total_cmds || due_results.size() != 0);
		repeat (TailCycles) @(negedge clk);

		if (fail_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

// ===== positional_list_engine.f =====
rtl/plm_pkg.sv
rtl/plm_cell.sv
rtl/positional_list_engine.sv
dv/positional_list_engine_tb.sv
